/* sv/lmks_pkg.sv */
// Shared types and constants for the LED matrix key scan controller.
`default_nettype none

package lmks_pkg;

  // Default sizes of the display RAM and the key matrix.
  localparam int DISPLAY_BYTES_DEF = 16;
  localparam int KEY_ROWS_DEF      = 3;
  localparam int KEY_COLUMNS_DEF   = 13;

  // Fixed widths of the bus fields.
  localparam int KEY_SCAN_W = 39;
  localparam int PTR_W      = 4;
  localparam int BYTE_W     = 8;

  // Item kinds on the input channel.
  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_SCAN   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  // Command byte opcodes, taken from bits 7:5 of the first written byte.
  typedef enum logic [2:0] {
    OP_DDAP   = 3'd0,
    OP_SS     = 3'd1,
    OP_KDAP   = 3'd2,
    OP_IFAP   = 3'd3,
    OP_DSP    = 3'd4,
    OP_RIS    = 3'd5,
    OP_UNUSED = 3'd6,
    OP_DIM    = 3'd7
  } op_t;

  // Region that bus reads are pointed at.
  typedef enum logic [1:0] {
    REGION_DISP = 2'd0,
    REGION_KEY  = 2'd1,
    REGION_INT  = 2'd2
  } region_t;

  // Output register occupancy.
  typedef enum logic {
    ST_EMPTY = 1'b0,
    ST_FULL  = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic hold;
  } ctl_t;

endpackage

`default_nettype wire

/* sv/lmks_ctrl.sv */
// Handshake controller: tracks the result register and issues item transfers.
`default_nettype none

module lmks_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output lmks_pkg::ctl_t     ctl
);

  lmks_pkg::state_t state_r;
  lmks_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lmks_pkg::ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    out_valid = 1'b0;
    in_ready  = 1'b0;
    unique case (state_r)
      lmks_pkg::ST_EMPTY: begin
        in_ready = 1'b1;
      end
      lmks_pkg::ST_FULL: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    ctl.take = in_valid && in_ready;
    ctl.hold = out_valid && !out_ready;
    if (ctl.take) begin
      state_nxt = lmks_pkg::ST_FULL;
    end else if (out_valid && out_ready) begin
      state_nxt = lmks_pkg::ST_EMPTY;
    end
  end

  // A taken item always leaves a result waiting in the next cycle.
  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.take |=> out_valid)
    else $error("result register not loaded after an item transfer");

  // A result that is not taken is never dropped.
  a_hold_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.hold |=> out_valid)
    else $error("pending result lost");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result register not empty after reset");

endmodule

`default_nettype wire

/* sv/lmks_dp.sv */
// Datapath: command decode, display and key RAMs, status registers and read data.
`default_nettype none

module lmks_dp #(
  parameter int DISPLAY_BYTES = lmks_pkg::DISPLAY_BYTES_DEF,
  parameter int KEY_ROWS      = lmks_pkg::KEY_ROWS_DEF,
  parameter int KEY_COLUMNS   = lmks_pkg::KEY_COLUMNS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire lmks_pkg::ctl_t                  ctl,
  input  wire logic [1:0]                      in_cmd,
  input  wire logic                            in_first,
  input  wire logic [lmks_pkg::BYTE_W-1:0]     in_wdata,
  input  wire logic [lmks_pkg::KEY_SCAN_W-1:0] in_key_scan,
  output logic [lmks_pkg::BYTE_W-1:0]          out_rdata,
  output logic                                 out_osc_on,
  output logic                                 out_display_on,
  output logic [1:0]                           out_blink_mode,
  output logic [3:0]                           out_dim_level,
  output logic [1:0]                           out_row_int_mode,
  output logic                                 out_int_flag
);

  localparam int DISP_AW   = (DISPLAY_BYTES > 1) ? $clog2(DISPLAY_BYTES) : 1;
  localparam int PTR_W     = lmks_pkg::PTR_W;
  localparam int PTR_DEPTH = 1 << PTR_W;
  localparam int KEY_BITS  = KEY_ROWS * KEY_COLUMNS;
  localparam int SCAN_EXT_W = (KEY_BITS > lmks_pkg::KEY_SCAN_W) ? KEY_BITS
                                                                : lmks_pkg::KEY_SCAN_W;
  localparam int KEY_BYTES = 2 * KEY_ROWS;

  logic [lmks_pkg::BYTE_W-1:0] disp_ram_r [DISPLAY_BYTES];
  logic [KEY_COLUMNS-1:0]      key_ram_r  [KEY_ROWS];
  lmks_pkg::region_t           region_r, region_nxt;
  logic [PTR_W-1:0]            ptr_r, ptr_nxt;
  logic                        data_phase_r, data_phase_nxt;
  logic                        osc_r, osc_nxt;
  logic [2:0]                  disp_setup_r, disp_setup_nxt;
  logic [3:0]                  dim_r, dim_nxt;
  logic [1:0]                  ris_r, ris_nxt;
  logic [lmks_pkg::BYTE_W-1:0] rdata_r, rdata_nxt;

  logic                        ram_we;
  logic                        key_we;
  logic [DISP_AW-1:0]          mod_tbl [PTR_DEPTH];
  logic [DISP_AW-1:0]          disp_idx;
  logic [PTR_W:0]              disp_sum;
  logic [PTR_W-1:0]            disp_next_ptr;
  logic [15:0]                 row_sel;
  logic [lmks_pkg::BYTE_W-1:0] key_byte;
  logic                        any_key;
  logic [SCAN_EXT_W-1:0]       scan_ext;
  lmks_pkg::cmd_t              cmd_w;
  lmks_pkg::op_t               op_w;

  // Pointer modulo display size, resolved at elaboration.
  for (genvar i = 0; i < PTR_DEPTH; i++) begin : g_mod
    assign mod_tbl[i] = DISP_AW'(i % DISPLAY_BYTES);
  end

  assign cmd_w    = lmks_pkg::cmd_t'(in_cmd);
  assign op_w     = lmks_pkg::op_t'(in_wdata[7:5]);
  assign scan_ext = SCAN_EXT_W'(in_key_scan);
  assign disp_idx = mod_tbl[ptr_r];
  assign disp_sum = (PTR_W + 1)'(disp_idx) + (PTR_W + 1)'(1);
  assign disp_next_ptr = (disp_sum >= (PTR_W + 1)'(DISPLAY_BYTES)) ? '0 : disp_sum[PTR_W-1:0];

  always_comb begin
    any_key = 1'b0;
    row_sel = '0;
    for (int r = 0; r < KEY_ROWS; r++) begin
      any_key = any_key | (|key_ram_r[r]);
      if (ptr_r[PTR_W-1:1] == (PTR_W - 1)'(r)) begin
        row_sel = 16'(key_ram_r[r]);
      end
    end
    if (ptr_r < PTR_W'(KEY_BYTES)) begin
      key_byte = ptr_r[0] ? row_sel[15:8] : row_sel[7:0];
    end else begin
      key_byte = '0;
    end
  end

  always_comb begin
    region_nxt     = region_r;
    ptr_nxt        = ptr_r;
    data_phase_nxt = data_phase_r;
    osc_nxt        = osc_r;
    disp_setup_nxt = disp_setup_r;
    dim_nxt        = dim_r;
    ris_nxt        = ris_r;
    rdata_nxt      = '0;
    ram_we         = 1'b0;
    key_we         = 1'b0;
    unique case (cmd_w)
      lmks_pkg::CMD_WRITE: begin
        if (in_first) begin
          data_phase_nxt = 1'b0;
          unique case (op_w)
            lmks_pkg::OP_DDAP: begin
              ptr_nxt        = PTR_W'(mod_tbl[in_wdata[PTR_W-1:0]]);
              region_nxt     = lmks_pkg::REGION_DISP;
              data_phase_nxt = 1'b1;
            end
            lmks_pkg::OP_SS:     osc_nxt = in_wdata[0];
            lmks_pkg::OP_KDAP: begin
              region_nxt = lmks_pkg::REGION_KEY;
              ptr_nxt    = in_wdata[PTR_W-1:0];
            end
            lmks_pkg::OP_IFAP:   region_nxt = lmks_pkg::REGION_INT;
            lmks_pkg::OP_DSP:    disp_setup_nxt = in_wdata[2:0];
            lmks_pkg::OP_RIS:    ris_nxt = in_wdata[1:0];
            lmks_pkg::OP_UNUSED: data_phase_nxt = 1'b0;
            lmks_pkg::OP_DIM:    dim_nxt = in_wdata[3:0];
            default:             data_phase_nxt = 1'b0;
          endcase
        end else if (data_phase_r) begin
          ram_we  = 1'b1;
          ptr_nxt = disp_next_ptr;
        end
      end
      lmks_pkg::CMD_READ: begin
        data_phase_nxt = 1'b0;
        unique case (region_r)
          lmks_pkg::REGION_DISP: begin
            rdata_nxt = disp_ram_r[disp_idx];
            ptr_nxt   = disp_next_ptr;
          end
          lmks_pkg::REGION_KEY: begin
            rdata_nxt = key_byte;
            ptr_nxt   = ptr_r + PTR_W'(1);
          end
          lmks_pkg::REGION_INT: begin
            rdata_nxt = lmks_pkg::BYTE_W'(any_key);
          end
          default: begin
            rdata_nxt = '0;
          end
        endcase
      end
      lmks_pkg::CMD_SCAN:   key_we = 1'b1;
      lmks_pkg::CMD_UNUSED: key_we = 1'b0;
      default:              key_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r     <= lmks_pkg::REGION_DISP;
      ptr_r        <= '0;
      data_phase_r <= 1'b0;
      osc_r        <= 1'b0;
      disp_setup_r <= '0;
      dim_r        <= '0;
      ris_r        <= '0;
      for (int i = 0; i < DISPLAY_BYTES; i++) begin
        disp_ram_r[i] <= '0;
      end
      for (int r = 0; r < KEY_ROWS; r++) begin
        key_ram_r[r] <= '0;
      end
    end else if (ctl.take) begin
      region_r     <= region_nxt;
      ptr_r        <= ptr_nxt;
      data_phase_r <= data_phase_nxt;
      osc_r        <= osc_nxt;
      disp_setup_r <= disp_setup_nxt;
      dim_r        <= dim_nxt;
      ris_r        <= ris_nxt;
      if (ram_we) begin
        disp_ram_r[disp_idx] <= in_wdata;
      end
      if (key_we) begin
        for (int r = 0; r < KEY_ROWS; r++) begin
          key_ram_r[r] <= scan_ext[r*KEY_COLUMNS +: KEY_COLUMNS];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      rdata_r <= rdata_nxt;
    end
  end

  // State only moves on a transfer, so the status fields belong to the held result.
  assign out_rdata        = rdata_r;
  assign out_osc_on       = osc_r;
  assign out_display_on   = disp_setup_r[0];
  assign out_blink_mode   = disp_setup_r[2:1];
  assign out_dim_level    = dim_r;
  assign out_row_int_mode = ris_r;
  assign out_int_flag     = any_key;

  // A display pointer command opens a display write.
  a_ddap_opens: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.take && cmd_w == lmks_pkg::CMD_WRITE && in_first && op_w == lmks_pkg::OP_DDAP
    |=> data_phase_r)
    else $error("display write not opened by pointer command");

  // Any read ends a display write.
  a_read_closes: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.take && cmd_w == lmks_pkg::CMD_READ |=> !data_phase_r)
    else $error("display write still open after a read");

  // A key scan event never moves the pointer.
  a_scan_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.take && cmd_w == lmks_pkg::CMD_SCAN |=> $stable(ptr_r))
    else $error("pointer moved on a key scan event");

endmodule

`default_nettype wire

/* sv/led_matrix_key_scan_controller_core.sv */
// Top level of the LED matrix key scan controller: serial command side.
// An input transfer's result appears on the out_ ports in the cycle after the transfer.
// Throughput: one item per cycle while out_ready is high; the next item is taken
// in the cycle the pending result goes out; the single result register is the only stage.
// Reset (rst_n low, synchronous) clears the display RAM, key rows and all
// control registers at once; no clearing pass follows.
`default_nettype none

module led_matrix_key_scan_controller_core #(
  parameter int DISPLAY_BYTES = lmks_pkg::DISPLAY_BYTES_DEF,
  parameter int KEY_ROWS      = lmks_pkg::KEY_ROWS_DEF,
  parameter int KEY_COLUMNS   = lmks_pkg::KEY_COLUMNS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      in_cmd,
  input  wire logic                            in_first,
  input  wire logic [lmks_pkg::BYTE_W-1:0]     in_wdata,
  input  wire logic [lmks_pkg::KEY_SCAN_W-1:0] in_key_scan,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [lmks_pkg::BYTE_W-1:0]          out_rdata,
  output logic                                 out_osc_on,
  output logic                                 out_display_on,
  output logic [1:0]                           out_blink_mode,
  output logic [3:0]                           out_dim_level,
  output logic [1:0]                           out_row_int_mode,
  output logic                                 out_int_flag
);

  // The controller decides when an item transfers; the datapath applies it.
  lmks_pkg::ctl_t ctl;

  lmks_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  // Every item updates the state and loads exactly one result. Status fields
  // show the state after the item that produced the pending result.
  lmks_dp #(
    .DISPLAY_BYTES (DISPLAY_BYTES),
    .KEY_ROWS      (KEY_ROWS),
    .KEY_COLUMNS   (KEY_COLUMNS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .in_cmd           (in_cmd),
    .in_first         (in_first),
    .in_wdata         (in_wdata),
    .in_key_scan      (in_key_scan),
    .out_rdata        (out_rdata),
    .out_osc_on       (out_osc_on),
    .out_display_on   (out_display_on),
    .out_blink_mode   (out_blink_mode),
    .out_dim_level    (out_dim_level),
    .out_row_int_mode (out_row_int_mode),
    .out_int_flag     (out_int_flag)
  );

endmodule

`default_nettype wire
